FILE: rtl/dswd_pkg.sv
// ----------------------------------------------------------------------------
// dswd_pkg
// Shared types and constants of the dual sensor wire detector.
// ----------------------------------------------------------------------------
package dswd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int BOUND_W    = 10;
    localparam int TICKS_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_UPPER_BOUND  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWER_BOUND  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TICKS = 2'd2;

    localparam logic [BOUND_W-1:0] UPPER_BOUND_RST  = 10'd580;
    localparam logic [BOUND_W-1:0] LOWER_BOUND_RST  = 10'd540;
    localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 16'd10;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic settling;
        logic sensor_select;
        logic wire_found;
        logic event_valid;
    } t_result;

endpackage

FILE: rtl/dswd_thresh.sv
// ----------------------------------------------------------------------------
// dswd_thresh
// Configuration registers. The bounds are kept as thresholds on the raw
// sample sum so that no division of the sum is needed.
// ----------------------------------------------------------------------------
module dswd_thresh #(
    parameter int NUM_SAMPLES = 20,
    parameter int THR_W       = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dswd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dswd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic [THR_W-1:0]                  o_set_thr,
    output logic [THR_W-1:0]                  o_clr_thr,
    output logic [dswd_pkg::TICKS_W-1:0]      o_settle_ticks
);

    localparam logic [THR_W-1:0] SET_THR_RST =
        THR_W'((int'(dswd_pkg::UPPER_BOUND_RST) + 1) * NUM_SAMPLES);
    localparam logic [THR_W-1:0] CLR_THR_RST =
        THR_W'(int'(dswd_pkg::LOWER_BOUND_RST) * NUM_SAMPLES);

    logic [THR_W-1:0]             r_set_thr;
    logic [THR_W-1:0]             r_clr_thr;
    logic [dswd_pkg::TICKS_W-1:0] r_settle_ticks;
    logic [THR_W-1:0]             n_set_thr;
    logic [THR_W-1:0]             n_clr_thr;
    logic [dswd_pkg::BOUND_W-1:0] w_bound;

    // A floor average above U means sum >= (U + 1) * N; below L means sum < L * N.
    assign w_bound   = i_cfg_wdata[dswd_pkg::BOUND_W-1:0];
    assign n_set_thr = (THR_W'(w_bound) + THR_W'(1)) * THR_W'(NUM_SAMPLES);
    assign n_clr_thr = THR_W'(w_bound) * THR_W'(NUM_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_thr      <= SET_THR_RST;
            r_clr_thr      <= CLR_THR_RST;
            r_settle_ticks <= dswd_pkg::SETTLE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dswd_pkg::REG_UPPER_BOUND: begin
                    r_set_thr <= n_set_thr;
                end
                dswd_pkg::REG_LOWER_BOUND: begin
                    r_clr_thr <= n_clr_thr;
                end
                dswd_pkg::REG_SETTLE_TICKS: begin
                    r_settle_ticks <= i_cfg_wdata[dswd_pkg::TICKS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_set_thr      = r_set_thr;
    assign o_clr_thr      = r_clr_thr;
    assign o_settle_ticks = r_settle_ticks;

endmodule

FILE: rtl/dswd_eval.sv
// ----------------------------------------------------------------------------
// dswd_eval
// Detector state and the single-pass update for one registered word:
// sample accumulation, hysteresis on the selected flag, events and settling.
// ----------------------------------------------------------------------------
module dswd_eval #(
    parameter int NUM_SAMPLES = 20,
    parameter int SUM_W       = 15,
    parameter int THR_W       = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  dswd_pkg::t_item               i_item,
    input  logic [THR_W-1:0]              i_set_thr,
    input  logic [THR_W-1:0]              i_clr_thr,
    input  logic [dswd_pkg::TICKS_W-1:0]  i_settle_ticks,
    output dswd_pkg::t_result             o_result
);

    localparam int CNT_W = $clog2(NUM_SAMPLES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SAMPLES - 1);

    logic [SUM_W-1:0]             r_sum;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_waiting;
    logic [dswd_pkg::TICKS_W-1:0] r_elapsed;
    logic [1:0]                   r_flags;
    logic                         r_active;

    logic [SUM_W-1:0]             n_sum;
    logic [CNT_W-1:0]             n_cnt;
    logic                         n_waiting;
    logic [dswd_pkg::TICKS_W-1:0] n_elapsed;
    logic [1:0]                   n_flags;
    logic                         n_active;

    logic [SUM_W-1:0]             w_sum_add;
    logic [THR_W-1:0]             w_sum_ext;
    logic [dswd_pkg::TICKS_W:0]   w_tick_next;
    logic                         w_own_flag;
    logic                         w_other_flag;
    logic                         w_set;
    logic                         w_clr;
    logic                         w_event;
    logic                         w_found;

    assign w_sum_add    = r_sum + SUM_W'(i_item.sample);
    assign w_sum_ext    = THR_W'(w_sum_add);
    assign w_tick_next  = {1'b0, r_elapsed} + {{dswd_pkg::TICKS_W{1'b0}}, 1'b1};
    assign w_own_flag   = r_flags[r_active];
    assign w_other_flag = r_flags[~r_active];
    assign w_set        = !w_own_flag && (w_sum_ext >= i_set_thr);
    assign w_clr        = w_own_flag && (w_sum_ext < i_clr_thr);

    always_comb begin
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_waiting = r_waiting;
        n_elapsed = r_elapsed;
        n_flags   = r_flags;
        n_active  = r_active;
        w_event   = 1'b0;
        w_found   = 1'b0;
        if (i_item.op == dswd_pkg::OP_TICK) begin
            if (r_waiting) begin
                if (w_tick_next > {1'b0, i_settle_ticks}) begin
                    n_waiting = 1'b0;
                    n_elapsed = '0;
                end else begin
                    n_elapsed = w_tick_next[dswd_pkg::TICKS_W-1:0];
                end
            end
        end else if (!r_waiting) begin
            n_sum = w_sum_add;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == LAST_CNT) begin
                if (w_set) begin
                    n_flags[r_active] = 1'b1;
                    w_event           = w_other_flag;
                    w_found           = w_other_flag;
                end else if (w_clr) begin
                    n_flags[r_active] = 1'b0;
                    w_event           = w_other_flag;
                end
                n_active  = ~r_active;
                n_waiting = 1'b1;
                n_elapsed = '0;
                n_sum     = '0;
                n_cnt     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_waiting <= 1'b0;
            r_elapsed <= '0;
            r_flags   <= '0;
            r_active  <= 1'b0;
        end else if (i_advance) begin
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_waiting <= n_waiting;
            r_elapsed <= n_elapsed;
            r_flags   <= n_flags;
            r_active  <= n_active;
        end
    end

    assign o_result.event_valid   = w_event;
    assign o_result.wire_found    = w_found;
    assign o_result.sensor_select = n_active;
    assign o_result.settling      = n_waiting;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_CNT)
        else $error("sample count passed the average length");

    a_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting |-> (r_cnt == '0 && r_sum == '0))
        else $error("accumulator not cleared while settling");

    a_idle_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_waiting |-> r_elapsed == '0)
        else $error("elapsed ticks nonzero outside settling");

    a_found_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_event && w_found) |=> r_flags == 2'b11)
        else $error("found event without both flags set");

    a_event_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_event) |=> (r_waiting && r_active != $past(r_active)))
        else $error("event without a sensor switch");

endmodule

FILE: rtl/dual_sensor_wire_detector_core.sv
// ----------------------------------------------------------------------------
// dual_sensor_wire_detector_core
// Averaging hysteresis comparator for two multiplexed wire sensors.
//
// Channel   Dir  Payload                                   Word rate
// s_axis    in   tuser: operation, tdata: sample           one per cycle
// m_axis    out  event_valid, wire_found, sensor_select,   one per input word
//                settling
// cfg       in   index 0 upper, 1 lower, 2 settle ticks    write when idle
//
// Each word passes an input register and a result register, and one word per
// cycle is sustained while the output is not stalled. The rate is set by the
// single state update between the two registers. Reset is synchronous and
// active low; it clears the valid flags and the detector state and loads the
// default bounds (580, 540) and settle count (10).
// A stalled output holds its word; the input register keeps taking words
// until it fills behind it.
// ----------------------------------------------------------------------------
module dual_sensor_wire_detector_core #(
    parameter int NUM_SAMPLES = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [9:0] sample, [15:10] zero
    input  logic [dswd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: [0] operation
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [0] event_valid, [1] wire_found, [2] sensor_select,
    // [3] settling, [7:4] zero
    output logic [dswd_pkg::M_TDATA_W-1:0]      m_axis_tdata,

    input  logic                                i_cfg_we,
    input  logic [dswd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dswd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int SUM_W = $clog2(NUM_SAMPLES * 1024);
    localparam int THR_W = SUM_W + 1;

    logic                         r_in_valid;
    dswd_pkg::t_item              r_in_item;
    logic                         r_out_valid;
    dswd_pkg::t_result            r_out_result;

    logic                         w_advance;
    logic                         w_in_accept;
    dswd_pkg::t_result            w_result;
    logic [THR_W-1:0]             w_set_thr;
    logic [THR_W-1:0]             w_clr_thr;
    logic [dswd_pkg::TICKS_W-1:0] w_settle_ticks;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item.op     <= s_axis_tuser;
            r_in_item.sample <= s_axis_tdata[dswd_pkg::SAMPLE_W-1:0];
        end
    end

    dswd_thresh #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .THR_W       (THR_W)
    ) u_thresh (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_set_thr      (w_set_thr),
        .o_clr_thr      (w_clr_thr),
        .o_settle_ticks (w_settle_ticks)
    );

    dswd_eval #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .SUM_W       (SUM_W),
        .THR_W       (THR_W)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_item         (r_in_item),
        .i_set_thr      (w_set_thr),
        .i_clr_thr      (w_clr_thr),
        .i_settle_ticks (w_settle_ticks),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_out_result.settling,
                            r_out_result.sensor_select,
                            r_out_result.wire_found,
                            r_out_result.event_valid};

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_result)))
        else $error("stalled result word was overwritten");

    a_fill_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both registers are full and stalled");

    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_result.wire_found |-> r_out_result.event_valid)
        else $error("found flag without an event");

endmodule

FILE: tb/dswd_wire_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dswd_wire_checker
// Watches the sample and result streams of the wire detector and checks
// every result word.
//
// The checker follows the configuration writes and keeps its own copy of the
// averaging, hysteresis and settling state. Each accepted input word yields
// one expected result word, queued in order. Each accepted result word is
// compared field by field with the oldest queued one. The number of queued
// words and the number of failures go back to the testbench top.
// ----------------------------------------------------------------------------
module dswd_wire_checker #(
    parameter int NUM_SAMPLES = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // tdata: [9:0] sample, [15:10] zero
    input  logic [dswd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: [0] operation
    input  logic                                s_axis_tuser,

    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [0] event_valid, [1] wire_found, [2] sensor_select,
    // [3] settling, [7:4] zero
    input  logic [dswd_pkg::M_TDATA_W-1:0]      m_axis_tdata,

    input  logic                                i_cfg_we,
    input  logic [dswd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dswd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,

    output int                                  o_pending,
    output int                                  o_fail_count
);

    import dswd_pkg::*;

    logic [BOUND_W-1:0]  upper_lim;
    logic [BOUND_W-1:0]  lower_lim;
    logic [TICKS_W-1:0]  settle_lim;

    logic [14:0]         level_sum;
    logic [5:0]          level_count;
    logic                settle_wait;
    logic [TICKS_W-1:0]  settle_elapsed;
    logic [1:0]          wire_seen;
    logic                active_sel;

    t_result             result_q[$];
    int                  fails = 0;

    task automatic check_bit(input string what, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s expected %0b, got %0b", $time, what, want, got);
            fails++;
        end
    endtask

    task automatic detect_step(input logic op, input logic [SAMPLE_W-1:0] smp,
                               output t_result res);
        logic [TICKS_W:0]   next_elapsed;
        logic [SAMPLE_W-1:0] avg;
        logic               sel;
        res = '0;
        if (op == OP_TICK) begin
            if (settle_wait) begin
                next_elapsed = settle_elapsed + 1'b1;
                if (next_elapsed > settle_lim) begin
                    settle_wait = 1'b0;
                    settle_elapsed = '0;
                end else begin
                    settle_elapsed = next_elapsed[TICKS_W-1:0];
                end
            end
        end else if (!settle_wait) begin
            level_sum = level_sum + smp;
            level_count = level_count + 1'b1;
            if (level_count >= NUM_SAMPLES) begin
                avg = SAMPLE_W'(level_sum / NUM_SAMPLES);
                sel = active_sel;
                // With the bounds crossed, a clear flag is set and a set flag is cleared; the tests never both apply.
                if (!wire_seen[sel] && avg > upper_lim) begin
                    wire_seen[sel] = 1'b1;
                    if (&wire_seen) begin
                        res.event_valid = 1'b1;
                        res.wire_found = 1'b1;
                    end
                end else if (wire_seen[sel] && avg < lower_lim) begin
                    if (&wire_seen) begin
                        res.event_valid = 1'b1;
                    end
                    wire_seen[sel] = 1'b0;
                end
                active_sel = ~sel;
                settle_wait = 1'b1;
                settle_elapsed = '0;
                level_sum = '0;
                level_count = '0;
            end
        end
        res.sensor_select = active_sel;
        res.settling = settle_wait;
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        t_result pred;
        if (!i_rst_n) begin
            upper_lim = UPPER_BOUND_RST;
            lower_lim = LOWER_BOUND_RST;
            settle_lim = SETTLE_TICKS_RST;
            level_sum = '0;
            level_count = '0;
            settle_wait = 1'b0;
            settle_elapsed = '0;
            wire_seen = '0;
            active_sel = 1'b0;
            result_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[3:0]);
                if (result_q.size() == 0) begin
                    $display("%0t: result word expected none, got %h", $time, m_axis_tdata);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_bit("event_valid", want.event_valid, got.event_valid);
                    check_bit("wire_found", want.wire_found, got.wire_found);
                    check_bit("sensor_select", want.sensor_select, got.sensor_select);
                    check_bit("settling", want.settling, got.settling);
                    if (m_axis_tdata[M_TDATA_W-1:4] !== '0) begin
                        $display("%0t: pad bits expected 0, got %h", $time,
                                 m_axis_tdata[M_TDATA_W-1:4]);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_UPPER_BOUND:  upper_lim = i_cfg_wdata[BOUND_W-1:0];
                    REG_LOWER_BOUND:  lower_lim = i_cfg_wdata[BOUND_W-1:0];
                    REG_SETTLE_TICKS: settle_lim = i_cfg_wdata[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                detect_step(s_axis_tuser, s_axis_tdata[SAMPLE_W-1:0], pred);
                result_q.push_back(pred);
            end
        end
        o_pending <= result_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/dual_sensor_wire_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_sensor_wire_detector_core_tb
// Stimulus and verdict for the dual sensor wire detector.
//
// Sample words come in rounds: one full average around a chosen level, with
// stray ticks mixed in, followed by the ticks that end the settling wait and
// stray samples that must be ignored. Levels sit above, below and exactly on
// the bounds so that both flags set and clear and found and lost events
// occur. The run passes through several bound and settle settings, including
// the extremes, with different idle and stall patterns on the two streams.
// ----------------------------------------------------------------------------
module dual_sensor_wire_detector_core_tb;

    import dswd_pkg::*;

    localparam int NUM_SAMPLES = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_sent = 0;
    int cur_upper = UPPER_BOUND_RST;
    int cur_lower = LOWER_BOUND_RST;
    int cur_settle = SETTLE_TICKS_RST;

    dual_sensor_wire_detector_core #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    dswd_wire_checker #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) checker_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= S_TDATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_UPPER_BOUND:  cur_upper = value % (1 << BOUND_W);
            REG_LOWER_BOUND:  cur_lower = value % (1 << BOUND_W);
            REG_SETTLE_TICKS: cur_settle = value % (1 << TICKS_W);
            default: ;
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] near_level(input int level, input int spread);
        int v;
        v = level - spread + int'($urandom_range(2 * spread));
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    task automatic feed_average(input int level, input int spread);
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            if ($urandom_range(9) == 0) send_word(OP_TICK, SAMPLE_W'($urandom));
            send_word(OP_SAMPLE, near_level(level, spread));
        end
    endtask

    task automatic wait_settle(input int ticks);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(3) == 0) send_word(OP_SAMPLE, SAMPLE_W'($urandom));
            send_word(OP_TICK, SAMPLE_W'($urandom));
        end
    endtask

    task automatic random_round();
        int level;
        int spread;
        case ($urandom_range(7))
            0, 1, 2: begin
                level = cur_upper + 1 + int'($urandom_range(40));
                spread = int'($urandom_range(30));
            end
            3, 4, 5: begin
                level = cur_lower - 1 - int'($urandom_range(40));
                spread = int'($urandom_range(30));
            end
            6: begin
                level = $urandom_range(1) ? cur_upper : cur_lower;
                spread = 0;
            end
            default: begin
                level = int'($urandom_range(SAMPLE_MAX));
                spread = int'($urandom_range(SAMPLE_MAX / 2));
            end
        endcase
        feed_average(level, spread);
        wait_settle(cur_settle + 1 + (($urandom_range(3) == 0) ? 2 : 0));
    endtask

    task automatic run_rounds(input int budget);
        int stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) random_round();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_UPPER_BOUND;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A tick outside the wait, one average from the ADC extremes, and a
        // sample that arrives during the wait.
        send_word(OP_TICK, '1);
        send_word(OP_SAMPLE, '0);
        for (int i = 1; i < NUM_SAMPLES; i++) send_word(OP_SAMPLE, '1);
        send_word(OP_SAMPLE, '0);
        wait_settle(cur_settle + 1);
        run_rounds(250);

        // A wait under the largest settle count is cut short by lowering
        // the count while the wait is running.
        write_reg(REG_SETTLE_TICKS, (1 << TICKS_W) - 1);
        feed_average(int'($urandom_range(SAMPLE_MAX)), 50);
        wait_settle(5);
        write_reg(REG_SETTLE_TICKS, 2);
        wait_settle(1);
        run_rounds(60);

        send_idle_pct = 65;
        recv_stall_pct = 0;
        write_reg(REG_UPPER_BOUND, SAMPLE_MAX);
        write_reg(REG_LOWER_BOUND, 0);
        write_reg(REG_SETTLE_TICKS, 0);
        run_rounds(150);
        write_reg(REG_UPPER_BOUND, 0);
        write_reg(REG_LOWER_BOUND, SAMPLE_MAX);
        run_rounds(200);

        send_idle_pct = 0;
        recv_stall_pct = 65;
        write_reg(REG_UPPER_BOUND, 300);
        write_reg(REG_LOWER_BOUND, 700);
        write_reg(REG_SETTLE_TICKS, 3);
        run_rounds(150);
        write_reg(REG_UPPER_BOUND, 700);
        write_reg(REG_LOWER_BOUND, 300);
        write_reg(REG_SETTLE_TICKS, 1);
        run_rounds(200);

        send_idle_pct = 10;
        recv_stall_pct = 10;
        repeat (4) begin
            write_reg(REG_UPPER_BOUND, int'($urandom_range((1 << CFG_DATA_W) - 1)));
            write_reg(REG_LOWER_BOUND, int'($urandom_range(SAMPLE_MAX)));
            write_reg(REG_SETTLE_TICKS, int'($urandom_range(12)));
            write_reg(REG_UNUSED, int'($urandom_range((1 << CFG_DATA_W) - 1)));
            run_rounds(90);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
